### design/rrta_pkg.sv
// Package for the round-robin timeslot allocator.
// Holds field widths, status and operation codes and the structs passed between modules.
// No dependencies.
package rrta_pkg;

  localparam int EP_W      = 8;    // endpoint number, circuit code
  localparam int LIM_W     = 9;    // endpoint limit, try counter
  localparam int MUX_W     = 4;    // multiplex index, one spare bit for the wrap
  localparam int TS_W      = 6;    // timeslot, one spare bit for the post-increment
  localparam int LIMIT_CEIL = 256; // limit saturates here so endpoints fit 8 bits

  localparam logic [TS_W-1:0]  TS_FIRST   = 6'd1;
  localparam logic [TS_W-1:0]  TS_LAST    = 6'd31;  // last timeslot, skipped by the candidate walk
  localparam logic [LIM_W-1:0] LIMIT_RST  = 9'd256;
  localparam logic [LIM_W-1:0] MUX_ROUND  = 9'd31;  // ceil(limit / 32) helper

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_NOT_BUSY  = 2'd3
  } status_t;

  // Candidate generator control
  typedef struct packed {
    logic load;  // restart the walk from last_granted
    logic step;  // advance to the next candidate
  } gen_ctrl_t;

  // Candidate generator status
  typedef struct packed {
    logic            avail;  // tries left under the limit
    logic [EP_W-1:0] ep;     // current candidate endpoint
  } cand_t;

endpackage

### design/rrta_ifs.sv
// Channel interfaces of the round-robin timeslot allocator.
// Request, result and configuration channels, each with valid/ready; no dependencies.
interface rrta_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] release_endpoint;

  modport source (output valid, output operation, output release_endpoint, input ready);
  modport sink   (input valid, input operation, input release_endpoint, output ready);
endinterface

interface rrta_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] granted_endpoint;
  logic [7:0] circuit_code;

  modport source (output valid, output status, output granted_endpoint, output circuit_code,
                  input ready);
  modport sink   (input valid, input status, input granted_endpoint, input circuit_code,
                  output ready);
endinterface

interface rrta_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] endpoint_limit;

  modport source (output valid, output endpoint_limit, input ready);
  modport sink   (input valid, input endpoint_limit, output ready);
endinterface

### design/rrta_busy_ram.sv
// Busy map storage: one bit per endpoint, one write and one read port.
// Read data is registered. Depends on nothing.
module rrta_busy_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rd_data
);

  logic mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/rrta_cand_gen.sv
// Round-robin candidate walk for the allocator search.
// Skips timeslots 0 and 31, wraps the multiplex, restarts at endpoint 1. Uses rrta_pkg.
module rrta_cand_gen
  import rrta_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  gen_ctrl_t        ctrl,
  input  logic [EP_W-1:0]  last_granted,
  input  logic [LIM_W-1:0] lim,
  output cand_t            cand
);

  logic [MUX_W-1:0] mux_r, mux_nxt;
  logic [TS_W-1:0]  ts_r, ts_nxt;
  logic [LIM_W-1:0] tries_r, tries_nxt;

  logic [LIM_W-1:0] lim_round;
  logic [MUX_W-1:0] muxes;
  logic [TS_W-1:0]  ts_a, ts_b, ts_c;
  logic [MUX_W-1:0] mux_a, mux_b, mux_c;
  logic [LIM_W-1:0] ep_raw;
  logic             restart;

  assign lim_round = lim + MUX_ROUND;
  assign muxes     = lim_round[LIM_W-1:5];

  always_comb begin
    // normalize the timeslot, skip the last slot into the next multiplex
    ts_a  = ((ts_r == '0) || (ts_r > TS_LAST)) ? TS_FIRST : ts_r;
    ts_b  = (ts_a == TS_LAST) ? TS_FIRST : ts_a;
    mux_a = (ts_a == TS_LAST) ? mux_r + MUX_W'(1) : mux_r;
    mux_b = (mux_a >= muxes) ? '0 : mux_a;
    ep_raw  = {mux_b, ts_b[4:0]};
    restart = (ep_raw >= lim);
    mux_c = restart ? '0 : mux_b;
    ts_c  = restart ? TS_FIRST : ts_b;
  end

  assign cand.ep    = restart ? EP_W'(1) : ep_raw[EP_W-1:0];
  assign cand.avail = (tries_r < lim);

  always_comb begin
    mux_nxt   = mux_r;
    ts_nxt    = ts_r;
    tries_nxt = tries_r;
    if (ctrl.load) begin
      mux_nxt   = MUX_W'(last_granted[7:5]);
      ts_nxt    = TS_W'(last_granted[4:0]) + TS_W'(1);
      tries_nxt = '0;
    end else if (ctrl.step) begin
      mux_nxt   = mux_c;
      ts_nxt    = ts_c + TS_W'(1);
      tries_nxt = tries_r + LIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mux_r   <= '0;
      ts_r    <= '0;
      tries_r <= '0;
    end else begin
      mux_r   <= mux_nxt;
      ts_r    <= ts_nxt;
      tries_r <= tries_nxt;
    end
  end

endmodule

### design/round_robin_timeslot_allocator_core.sv
// Round-robin timeslot allocator, top level.
// Uses rrta_pkg, the rrta_*_if channel interfaces, rrta_busy_ram and rrta_cand_gen.
//
// Hands out circuit endpoints (multiplex*32 + timeslot) from a busy map held in a
// one-bit-wide synchronous RAM. Items are taken one at a time. An allocate beat walks the
// map round-robin from the slot after the last grant, one candidate per cycle: the RAM
// read of the next candidate overlaps the check of the previous one. A search runs through
// the accept, one read per candidate (at most endpoint_limit of them), the final check and
// the hand-over of the result to the output register. A release beat runs through accept,
// read, check and write back, and result. The RAM read port is what sets the pace of both.
// After reset the map's min(ENDPOINT_CAPACITY, 256) entries are cleared one per cycle,
// during which no request beat is taken; configuration writes are taken at any time and
// must only be issued while the block is idle. A finished result sits in the output
// register until taken, while the next request is already accepted and worked on. Every
// request gives exactly one result beat.
module round_robin_timeslot_allocator_core
  import rrta_pkg::*;
#(
  parameter int ENDPOINT_CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  rrta_cfg_if.sink   cfg_bus,
  rrta_in_if.sink    in_bus,
  rrta_out_if.source out_bus
);

  // Endpoints above 255 can never be reached, so the map stops there.
  localparam int MAP_DEPTH = (ENDPOINT_CAPACITY < LIMIT_CEIL) ? ENDPOINT_CAPACITY : LIMIT_CEIL;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam logic [LIM_W-1:0]  MAP_LIMIT = LIM_W'(MAP_DEPTH);
  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(MAP_DEPTH - 1);

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_SEARCH  = 6'b000100,
    S_REL_RD  = 6'b001000,
    S_REL_CHK = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [LIM_W-1:0]  limit_r, limit_nxt;
  logic [EP_W-1:0]   last_r, last_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // search pipeline: candidate whose map bit is being read
  logic              pend_r, pend_nxt;
  logic [EP_W-1:0]   pend_ep_r, pend_ep_nxt;

  // release request held for the read-modify-write
  logic [EP_W-1:0]   rel_r, rel_nxt;

  // finished result waiting for the output register
  status_t           res_status_r, res_status_nxt;
  logic [EP_W-1:0]   res_ep_r, res_ep_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [EP_W-1:0]   out_ep_r, out_ep_nxt;

  logic [LIM_W-1:0]  lim_eff;
  logic              in_accept;
  logic              out_free;
  logic              hit;
  logic              rel_in_map;

  gen_ctrl_t         gen_ctrl;
  cand_t             cand;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic              ram_rd_data;

  // saturate the limit to the map size
  assign lim_eff   = (limit_r > MAP_LIMIT) ? MAP_LIMIT : limit_r;

  assign in_bus.ready  = (state_r == S_IDLE);
  assign in_accept     = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  assign out_free   = !out_valid_r || out_bus.ready;
  // candidate read last cycle came back free
  assign hit        = pend_r && !ram_rd_data;
  assign rel_in_map = ({1'b0, rel_r} < MAP_LIMIT);

  rrta_cand_gen u_cand_gen (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (gen_ctrl),
    .last_granted (last_r),
    .lim          (lim_eff),
    .cand         (cand)
  );

  rrta_busy_ram #(
    .DEPTH  (MAP_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_busy_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    last_nxt       = last_r;
    clr_addr_nxt   = clr_addr_r;
    pend_nxt       = 1'b0;
    pend_ep_nxt    = pend_ep_r;
    rel_nxt        = rel_r;
    res_status_nxt = res_status_r;
    res_ep_nxt     = res_ep_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_ep_nxt     = out_ep_r;

    gen_ctrl  = '0;
    ram_we    = 1'b0;
    ram_waddr = pend_ep_r[ADDR_W-1:0];
    ram_wdata = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = cand.ep[ADDR_W-1:0];

    if (cfg_bus.valid) begin
      limit_nxt = cfg_bus.endpoint_limit;
    end

    // drop the output beat once taken
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        // sweep the map clear, one entry per cycle
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = 1'b0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          rel_nxt = in_bus.release_endpoint;
          if (op_t'(in_bus.operation) == OP_ALLOC) begin
            gen_ctrl.load = 1'b1;
            state_nxt     = S_SEARCH;
          end else begin
            state_nxt = S_REL_RD;
          end
        end
      end

      S_SEARCH: begin
        priority if (hit) begin
          // claim the free slot; the search ends here, no later read can race it
          ram_we         = 1'b1;
          ram_waddr      = pend_ep_r[ADDR_W-1:0];
          ram_wdata      = 1'b1;
          last_nxt       = pend_ep_r;
          res_status_nxt = ST_GRANTED;
          res_ep_nxt     = pend_ep_r;
          state_nxt      = S_DONE;
        end else if (cand.avail) begin
          // read the next candidate while the previous one is checked
          ram_re        = 1'b1;
          ram_raddr     = cand.ep[ADDR_W-1:0];
          gen_ctrl.step = 1'b1;
          pend_nxt      = 1'b1;
          pend_ep_nxt   = cand.ep;
        end else begin
          // tries used up and no pending candidate read came back free
          res_status_nxt = ST_NONE_FREE;
          res_ep_nxt     = '0;
          state_nxt      = S_DONE;
        end
      end

      S_REL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rel_r[ADDR_W-1:0];
        state_nxt = S_REL_CHK;
      end

      S_REL_CHK: begin
        res_ep_nxt = '0;
        if (rel_in_map && ram_rd_data) begin
          ram_we         = 1'b1;
          ram_waddr      = rel_r[ADDR_W-1:0];
          ram_wdata      = 1'b0;
          res_status_nxt = ST_RELEASED;
        end else begin
          res_status_nxt = ST_NOT_BUSY;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_ep_nxt     = res_ep_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      limit_r     <= LIMIT_RST;
      last_r      <= '0;
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      last_r      <= last_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_ep_r    <= pend_ep_nxt;
    rel_r        <= rel_nxt;
    res_status_r <= res_status_nxt;
    res_ep_r     <= res_ep_nxt;
    out_status_r <= out_status_nxt;
    out_ep_r     <= out_ep_nxt;
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.status           = out_status_r;
  assign out_bus.granted_endpoint = out_ep_r;
  assign out_bus.circuit_code     = {out_ep_r[7:5], out_ep_r[4:0]};

  // state register stays one-hot
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("allocator state not one-hot");

  // a pending candidate read only exists inside a search
  a_pend_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SEARCH))
    else $error("candidate read outstanding outside search");

  // a grant never lands on timeslot 0 or 31
  a_grant_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && hit) |->
      (pend_ep_r[4:0] != 5'd0 && pend_ep_r[4:0] != 5'd31))
    else $error("grant on a reserved timeslot");

  // a grant stays under the limit, but for the restart slot
  a_grant_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && hit) |-> (({1'b0, pend_ep_r} < lim_eff) || pend_ep_r == 8'd1))
    else $error("grant beyond the endpoint limit");

  // an accepted request leaves idle on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_SEARCH || state_r == S_REL_RD))
    else $error("request accepted without starting work");

endmodule
